/* src/nand_bad_block_table_top_assert.svh */
// assertion macros for the bad block table
// expects clk and rst in the including module's scope
`ifndef NAND_BAD_BLOCK_TABLE_TOP_ASSERT_SVH
`define NAND_BAD_BLOCK_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define NBBT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbbt assertion failed");

// next-cycle implication
`define NBBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbbt assertion failed");

`endif

/* src/nbbt_pkg.sv */
// shared types and constants for the bad block table
// no dependencies
`default_nettype none

package nbbt_pkg;

  localparam int WORD_BITS = 16;
  localparam int WK_W      = 4;

  localparam logic [2:0] REQ_FACTORY     = 3'd0;
  localparam logic [2:0] REQ_MARK        = 3'd1;
  localparam logic [2:0] REQ_QUERY       = 3'd2;
  localparam logic [2:0] REQ_FIRST_VALID = 3'd3;
  localparam logic [2:0] REQ_NEXT_BAD    = 3'd4;

  localparam logic [1:0] CFG_SCAN_LOW    = 2'd0;
  localparam logic [1:0] CFG_SCAN_HIGH   = 2'd1;
  localparam logic [1:0] CFG_FIRST_ALLOC = 2'd2;

  localparam logic [7:0] MARK_ERASED = 8'hFF;

  typedef struct packed {
    logic            want_set;
    logic            lo_en;
    logic [WK_W-1:0] lo_k;
    logic            hi_en;
    logic [WK_W-1:0] hi_k;
  } scan_ctl_t;

  typedef struct packed {
    logic            hit;
    logic [WK_W-1:0] k;
  } scan_res_t;

endpackage

`default_nettype wire

/* src/nbbt_flag_ram.sv */
// flag store: one row of flags per address, registered read
// depends on nbbt_pkg
`default_nettype none

module nbbt_flag_ram import nbbt_pkg::*; #(
  parameter int ROWS  = 128,
  parameter int ROW_W = 7
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ROW_W-1:0]     waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic [ROW_W-1:0]     raddr,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/nbbt_word_scan.sv */
// finds the lowest flag of the wanted value inside a bounded span of one row
// depends on nbbt_pkg
`default_nettype none

module nbbt_word_scan import nbbt_pkg::*; (
  input  wire scan_ctl_t            ctl,
  input  wire logic [WORD_BITS-1:0] word,
  output scan_res_t                 res
);

  always_comb begin
    logic            cand;
    logic [WK_W-1:0] ki;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      ki   = WK_W'(i);
      cand = (word[i] == ctl.want_set) && (!ctl.lo_en || ki >= ctl.lo_k) &&
             (!ctl.hi_en || ki <= ctl.hi_k);
      if (cand) begin
        res.hit = 1'b1;
        res.k   = ki;
      end
    end
  end

endmodule

`default_nettype wire

/* src/nand_bad_block_table_top.sv */
// table operations read their flag row, evaluate it in the eval state and register
// their word with done; searches walk one flag row a cycle (16 blocks a row) until
// a hit, the last row or an empty span; a new request is taken only while idle, once the last is done
// done strobes for one cycle; the receiver cannot stall
// reset clears the flag store by a pass of one row a cycle (128 rows by default),
// busy stays high meanwhile; configuration writes are taken at all times outside reset
`default_nettype none

module nand_bad_block_table_top import nbbt_pkg::*; #(
  parameter int NUM_BLOCKS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [11:0] block_index,
  input  wire logic [7:0]  main_marker,
  input  wire logic [7:0]  spare_marker,
  input  wire logic        read_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  output logic             done,
  output logic             is_bad,
  output logic             found,
  output logic [10:0]      result_block,
  output logic [11:0]      bad_count,
  output logic             write_marker
);

  localparam int ROWS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = ($clog2(NUM_BLOCKS + 1) > 12) ? $clog2(NUM_BLOCKS + 1) : 12;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]       state, state_next;
  logic [ROW_W-1:0] row, row_next, last_row;
  logic             first, first_next;
  logic [2:0]       req;
  logic [WK_W-1:0]  blk_k, lo_k, hi_k;
  logic             in_range, inside_win, marker_bad, empty;
  logic [11:0]      scan_low;
  logic [10:0]      scan_high, first_alloc;

  logic [11:0] bad_count_next;
  logic        done_next, is_bad_next, found_next, write_marker_next;
  logic [10:0] result_block_next;

  logic                 we;
  logic [WORD_BITS-1:0] wdata, rd_word;
  logic [CW-1:0]        blk_ext, fv_hi, lo, hi, hi_m1;
  logic                 old_bit, new_bit;
  scan_ctl_t            scan_ctl;
  scan_res_t            scan_res;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // request setup
  assign blk_ext = CW'(block_index);
  assign fv_hi   = (CW'(scan_high) < CW'(NUM_BLOCKS)) ? CW'(scan_high) : CW'(NUM_BLOCKS);
  assign lo      = (req_type == REQ_FIRST_VALID) ? CW'(first_alloc) : blk_ext;
  assign hi      = (req_type == REQ_FIRST_VALID) ? fv_hi : CW'(NUM_BLOCKS);
  assign hi_m1   = hi - CW'(1);

  nbbt_flag_ram #(.ROWS(ROWS), .ROW_W(ROW_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (row),
    .wdata (wdata),
    .raddr (row_next),
    .rdata (rd_word)
  );

  assign scan_ctl.want_set = (req == REQ_NEXT_BAD);
  assign scan_ctl.lo_en    = first;
  assign scan_ctl.lo_k     = lo_k;
  assign scan_ctl.hi_en    = (row == last_row);
  assign scan_ctl.hi_k     = hi_k;

  nbbt_word_scan u_scan (
    .ctl  (scan_ctl),
    .word (rd_word),
    .res  (scan_res)
  );

  assign old_bit = rd_word[blk_k];
  assign new_bit = inside_win && marker_bad;

  always_comb begin
    state_next        = state;
    row_next          = row;
    first_next        = first;
    we                = 1'b0;
    wdata             = rd_word;
    bad_count_next    = bad_count;
    done_next         = 1'b0;
    is_bad_next       = is_bad;
    found_next        = found;
    result_block_next = result_block;
    write_marker_next = write_marker;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (row == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
          row_next   = '0;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EVAL;
          row_next   = ROW_W'(lo >> WK_W);
          first_next = 1'b1;
        end
      end
      ST_EVAL: begin
        found_next        = 1'b0;
        result_block_next = '0;
        write_marker_next = 1'b0;
        is_bad_next       = 1'b0;
        case (req)
          REQ_FACTORY, REQ_MARK, REQ_QUERY: begin
            done_next   = 1'b1;
            state_next  = ST_IDLE;
            is_bad_next = 1'b1;
            if (in_range) begin
              if (req == REQ_FACTORY) begin
                wdata[blk_k] = new_bit;
                we           = (new_bit != old_bit);
                is_bad_next  = new_bit;
                if (new_bit && !old_bit) begin
                  bad_count_next = bad_count + 12'd1;
                end else if (!new_bit && old_bit) begin
                  bad_count_next = bad_count - 12'd1;
                end
              end else if (req == REQ_MARK) begin
                wdata[blk_k] = 1'b1;
                if (!old_bit) begin
                  we                = 1'b1;
                  bad_count_next    = bad_count + 12'd1;
                  write_marker_next = 1'b1;
                end
              end else begin
                is_bad_next = old_bit;
              end
            end
          end
          REQ_FIRST_VALID, REQ_NEXT_BAD: begin
            if (empty) begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else if (scan_res.hit) begin
              done_next         = 1'b1;
              state_next        = ST_IDLE;
              found_next        = 1'b1;
              result_block_next = 11'({row, scan_res.k});
            end else if (row == last_row) begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              row_next   = row + ROW_W'(1);
              first_next = 1'b0;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      row          <= '0;
      first        <= 1'b0;
      bad_count    <= '0;
      done         <= 1'b0;
      is_bad       <= 1'b0;
      found        <= 1'b0;
      result_block <= '0;
      write_marker <= 1'b0;
    end else begin
      state        <= state_next;
      row          <= row_next;
      first        <= first_next;
      bad_count    <= bad_count_next;
      done         <= done_next;
      is_bad       <= is_bad_next;
      found        <= found_next;
      result_block <= result_block_next;
      write_marker <= write_marker_next;
    end
  end

  // request word capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req        <= req_type;
      blk_k      <= block_index[WK_W-1:0];
      in_range   <= (blk_ext < CW'(NUM_BLOCKS));
      inside_win <= (block_index >= scan_low) && ({1'b0, scan_high} >= block_index);
      marker_bad <= read_ok && ((main_marker != MARK_ERASED) ||
                                (spare_marker != MARK_ERASED));
      empty      <= !(lo < hi);
      lo_k       <= lo[WK_W-1:0];
      hi_k       <= hi_m1[WK_W-1:0];
      last_row   <= ROW_W'(hi_m1 >> WK_W);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_low    <= 12'd0;
      scan_high   <= 11'd2047;
      first_alloc <= 11'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCAN_LOW:    scan_low    <= cfg_data;
        CFG_SCAN_HIGH:   scan_high   <= cfg_data[10:0];
        CFG_FIRST_ALLOC: first_alloc <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

`include "nand_bad_block_table_top_assert.svh"

  `NBBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `NBBT_ASSERT_IMPLY(a_done_idle, done, !busy)
  `NBBT_ASSERT_NEXT(a_done_single, done, !done)
  `NBBT_ASSERT_IMPLY(a_wmark_mark_only, done && write_marker, is_bad && !found)

endmodule

`default_nettype wire
